// ===== rtl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Widths of the payload fields.
   localparam int CNT_W = 7;
   localparam int IDX_W = 6;
   localparam int ORD_W = 3;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_INVALID  = 2'd1,
      STAT_TOO_FEW  = 2'd2,
      STAT_NO_PIECE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/bba_ifs.sv =====
// Handshake channels of the buddy block allocator: request, response and register write.
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if import bba_pkg::*;;
   logic                   valid;
   logic                   ready;
   command_type            command;
   logic [CNT_W-1:0]       block_count;
   logic [IDX_W-1:0]       block_index;

   modport source (output valid, output command, output block_count, output block_index,
                   input ready);
   modport sink (input valid, input command, input block_count, input block_index,
                 output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [IDX_W-1:0]       granted_index;
   logic [CNT_W-1:0]       free_total;

   modport source (output valid, output status, output granted_index, output free_total,
                   input ready);
   modport sink (input valid, input status, input granted_index, input free_total,
                 output ready);
endinterface

interface bba_csr_if import bba_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CNT_W-1:0]       total_blocks;

   modport source (output valid, output total_blocks, input ready);
   modport sink (input valid, input total_blocks, output ready);
endinterface

`default_nettype wire

// ===== rtl/buddy_block_allocator_unit.sv =====
// Binary buddy allocator: one free bit map per order, held in a synchronous memory.
// One request beat is worked on at a time, and a new beat is taken only once back in idle;
//   the single synchronous read port of the map memory sets the pace.
// Reset (synchronous, active high) loads the total with NUM_BLOCKS and then rebuilds the maps,
//   one order per cycle from order 0 up to MAX_ORDER, during which no request beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_unit import bba_pkg::*; #(
   parameter int NUM_BLOCKS = 64,
   parameter int MAX_ORDER  = 6
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_bus,
   bba_rsp_if.source rsp_bus,
   bba_csr_if.sink   csr_bus
);

   // Address width of the order-indexed map memory.
   localparam int AW = $clog2(MAX_ORDER + 1);
   localparam logic [ORD_W-1:0] MAX_ORD   = ORD_W'(MAX_ORDER);
   localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(NUM_BLOCKS);
   // Sizes above the largest order are never part of the free maps.
   localparam logic [CNT_W-1:0] CNT_MASK  = CNT_W'((2 ** (MAX_ORDER + 1)) - 1);

   typedef logic [NUM_BLOCKS-1:0] map_type;
   localparam map_type MAP_ONE = map_type'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REBUILD,
      ST_A_RD,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_OUT
   } state_type;

   // Smallest k with 2^k >= n; 7 when n exceeds 64.
   function automatic logic [ORD_W-1:0] ceil_order(input logic [CNT_W-1:0] n);
      logic [ORD_W-1:0] r;
      r = ORD_W'(7);
      for (int j = 6; j >= 0; j--) begin
         if ((8'(1) << j) >= {1'b0, n}) begin
            r = ORD_W'(j);
         end
      end
      return r;
   endfunction

   // Highest order present in the decomposition of a total.
   function automatic logic [ORD_W-1:0] top_of(input logic [CNT_W-1:0] t);
      logic [CNT_W-1:0] m;
      logic [ORD_W-1:0] r;
      m = t & CNT_MASK;
      r = '0;
      for (int j = 0; j < CNT_W; j++) begin
         if (m[j]) begin
            r = ORD_W'(j);
         end
      end
      return r;
   endfunction

   // Index of the lowest set bit of a map word.
   function automatic logic [IDX_W-1:0] lowest_bit(input map_type v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   // Control and payload registers.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [ORD_W-1:0] top_order_ff, top_order_in;
   logic [ORD_W-1:0] k_ff, k_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [ORD_W-1:0] sp_ff, sp_in;
   logic [ORD_W-1:0] rb_ff, rb_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] granted_ff, granted_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [CNT_W-1:0] rsp_free_ff, rsp_free_in;

   // Map memory: entry o holds the free bit map of order o.
   map_type          map_mem [MAX_ORDER + 1];
   map_type          rd_data_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   map_type          mem_wdata;
   logic             mem_re;
   logic [AW-1:0]    mem_raddr;

   // Decoded values.
   logic             req_fire;
   logic             csr_fire;
   logic             out_free;
   logic [ORD_W-1:0] req_k;
   logic [7:0]       req_size;
   logic [7:0]       k_size;
   logic [CNT_W-1:0] csr_total;
   map_type          span;
   logic [IDX_W-1:0] ord_base;
   logic [IDX_W-1:0] buddy;
   map_type          base_shift;
   map_type          buddy_shift;
   logic             cover_hit;
   logic [IDX_W-1:0] low_idx;
   logic [CNT_W-1:0] rb_pos;
   map_type          rb_row;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready         = (state_ff == ST_IDLE);
   // A total write waits until the sequencer is idle or rebuilding; a request beat offered in the
   // same cycle is taken first, so no accepted beat is ever dropped.
   assign csr_bus.ready         = (state_ff == ST_REBUILD) ||
                                  (state_ff == ST_IDLE && !req_bus.valid);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_index = rsp_granted_ff;
   assign rsp_bus.free_total    = rsp_free_ff;

   // Request count rounded up to a power of two.
   assign req_k    = ceil_order(req_bus.block_count);
   assign req_size = 8'(1) << req_k;
   assign k_size   = 8'(1) << k_ff;

   // A written total above the region size saturates.
   assign csr_total = (csr_bus.total_blocks > TOTAL_MAX) ? TOTAL_MAX : csr_bus.total_blocks;

   // Overlap test of a freed piece against one order's map. Orders at or below the
   // freed size can hold several pieces inside the span; a larger order can only hold
   // the one aligned piece that contains the span.
   assign span        = ((MAP_ONE << k_size) - MAP_ONE) << idx_ff;
   assign ord_base    = idx_ff & ~IDX_W'((7'(1) << ord_ff) - 7'(1));
   assign base_shift  = rd_data_ff >> ord_base;
   assign cover_hit   = (ord_ff <= k_ff) ? (|(rd_data_ff & span)) : base_shift[0];

   // Buddy of the piece being merged at the current order.
   assign buddy       = idx_ff ^ IDX_W'(7'(1) << ord_ff);
   assign buddy_shift = rd_data_ff >> buddy;

   assign low_idx = lowest_bit(rd_data_ff);

   // Rebuild row for order rb_ff: the piece sits after all larger pieces of the total.
   assign rb_pos = total_ff & CNT_MASK & ~CNT_W'((8'(2) << rb_ff) - 8'(1));
   assign rb_row = total_ff[rb_ff] ? (MAP_ONE << rb_pos) : '0;

   always_comb begin
      state_in       = state_ff;
      total_in       = total_ff;
      free_count_in  = free_count_ff;
      top_order_in   = top_order_ff;
      k_in           = k_ff;
      ord_in         = ord_ff;
      sp_in          = sp_ff;
      rb_in          = rb_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      mem_we         = 1'b0;
      mem_waddr      = ord_ff[AW-1:0];
      mem_wdata      = rd_data_ff;
      mem_re         = 1'b0;
      mem_raddr      = ord_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               granted_in = '0;
               k_in       = req_k;
               idx_in     = req_bus.block_index;
               state_in   = ST_OUT;
               if (req_bus.command == CMD_ALLOC) begin
                  if (req_bus.block_count == '0) begin
                     status_in = STAT_INVALID;
                  end else if (req_size > {1'b0, free_count_ff}) begin
                     status_in = STAT_TOO_FEW;
                  end else if (req_k > MAX_ORD || req_k > top_order_ff) begin
                     status_in = STAT_NO_PIECE;
                  end else begin
                     // Scan upward from the requested order.
                     ord_in   = req_k;
                     state_in = ST_A_RD;
                  end
               end else begin
                  if (req_bus.block_count == '0 || req_k > MAX_ORD) begin
                     status_in = STAT_INVALID;
                  end else if ((req_bus.block_index & IDX_W'(req_size - 8'd1)) != '0) begin
                     status_in = STAT_INVALID;
                  end else if ({2'b00, req_bus.block_index} + req_size > {1'b0, total_ff}) begin
                     status_in = STAT_INVALID;
                  end else begin
                     // Check every order for blocks already free inside the piece.
                     ord_in   = '0;
                     state_in = ST_F_RD;
                  end
               end
            end
         end

         ST_REBUILD: begin
            mem_we    = 1'b1;
            mem_waddr = rb_ff[AW-1:0];
            mem_wdata = rb_row;
            if (rb_ff == MAX_ORD) begin
               state_in = ST_IDLE;
            end else begin
               rb_in = rb_ff + 1'b1;
            end
         end

         ST_A_RD: begin
            mem_re   = 1'b1;
            state_in = ST_A_CHK;
         end

         ST_A_CHK: begin
            if (rd_data_ff != '0) begin
               // Take the lowest free piece of this order.
               mem_we        = 1'b1;
               mem_wdata     = rd_data_ff & ~(MAP_ONE << low_idx);
               idx_in        = low_idx;
               sp_in         = k_ff;
               status_in     = STAT_OK;
               granted_in    = low_idx;
               free_count_in = free_count_ff - CNT_W'(k_size);
               state_in      = (k_ff < ord_ff) ? ST_A_SPLIT : ST_OUT;
            end else if (ord_ff >= top_order_ff) begin
               status_in = STAT_NO_PIECE;
               state_in  = ST_OUT;
            end else begin
               ord_in   = ord_ff + 1'b1;
               state_in = ST_A_RD;
            end
         end

         ST_A_SPLIT: begin
            // Orders from the requested one up to the one found were empty, so each gets only its upper half.
            mem_we    = 1'b1;
            mem_waddr = sp_ff[AW-1:0];
            mem_wdata = MAP_ONE << (idx_ff + IDX_W'(7'(1) << sp_ff));
            sp_in     = sp_ff + 1'b1;
            if (ORD_W'(sp_ff + 1'b1) == ord_ff) begin
               state_in = ST_OUT;
            end
         end

         ST_F_RD: begin
            mem_re   = 1'b1;
            state_in = ST_F_CHK;
         end

         ST_F_CHK: begin
            if (cover_hit) begin
               status_in = STAT_INVALID;
               state_in  = ST_OUT;
            end else if (ord_ff == MAX_ORD) begin
               ord_in   = k_ff;
               state_in = ST_M_RD;
            end else begin
               ord_in   = ord_ff + 1'b1;
               state_in = ST_F_RD;
            end
         end

         ST_M_RD: begin
            mem_re   = 1'b1;
            state_in = ST_M_CHK;
         end

         ST_M_CHK: begin
            mem_we = 1'b1;
            if (ord_ff < MAX_ORD && {1'b0, buddy} < total_ff && buddy_shift[0]) begin
               // Buddy is free: pull it out and climb one order with the merged piece.
               mem_wdata = rd_data_ff & ~(MAP_ONE << buddy);
               idx_in    = idx_ff & ~IDX_W'(7'(1) << ord_ff);
               ord_in    = ord_ff + 1'b1;
               state_in  = ST_M_RD;
            end else begin
               mem_wdata     = rd_data_ff | (MAP_ONE << idx_ff);
               free_count_in = free_count_ff + CNT_W'(k_size);
               status_in     = STAT_OK;
               state_in      = ST_OUT;
            end
         end

         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = granted_ff;
               rsp_free_in    = free_count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A total write restarts the rebuild of all maps.
      if (csr_fire) begin
         total_in      = csr_total;
         free_count_in = csr_total & CNT_MASK;
         top_order_in  = top_of(csr_total);
         rb_in         = '0;
         state_in      = ST_REBUILD;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_REBUILD;
         rb_ff         <= '0;
         total_ff      <= TOTAL_MAX;
         free_count_ff <= TOTAL_MAX & CNT_MASK;
         top_order_ff  <= top_of(TOTAL_MAX);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rb_ff          <= rb_in;
         total_ff       <= total_in;
         free_count_ff  <= free_count_in;
         top_order_ff   <= top_order_in;
         rsp_valid_ff   <= rsp_valid_in;
         k_ff           <= k_in;
         ord_ff         <= ord_in;
         sp_ff          <= sp_in;
         idx_ff         <= idx_in;
         status_ff      <= status_in;
         granted_ff     <= granted_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_free_ff    <= rsp_free_in;
      end
   end

   // The free total can never exceed the managed total.
   a_free_le_total: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= total_ff)
      else $error("free count above total");

   // The sequencer never reads an order in the cycle it writes that order.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("map read and write to the same order");

   // A nonzero grant comes only with a successful allocate.
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff != '0) |-> (rsp_status_ff == STAT_OK))
      else $error("grant index on a failed beat");

   // An accepted beat moves the sequencer out of idle.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !csr_fire) |=> (state_ff != ST_IDLE))
      else $error("request beat accepted without starting work");

endmodule

`default_nettype wire

// ===== tb/buddy_block_allocator_unit_tb.sv =====
// Self-checking testbench of the buddy block allocator: directed and random requests.
`timescale 1ns / 1ps

module buddy_block_allocator_unit_tb;
   import bba_pkg::*;

   localparam int NUM_BLOCKS = 64;
   localparam int MAX_ORDER  = 6;

   // What one response beat should carry.
   typedef struct packed {
      status_type             status;
      logic [IDX_W-1:0]       granted;
      logic [CNT_W-1:0]       free_total;
   } outcome_type;

   // A piece handed out by an allocate, kept so that later frees can return it.
   typedef struct {
      int unsigned base;
      int unsigned count;
   } piece_type;

   // Tracks the free sets of the allocator and the responses still owed.
   class allocator_board_type;
      logic [63:0] free_map [0:MAX_ORDER];
      int unsigned free_count;
      int unsigned top_order;
      int unsigned total;
      outcome_type expected_q [$];
      piece_type   live [$];
      int unsigned errors;
      int unsigned checked;
      int unsigned requests;
      int unsigned settings;
      int unsigned status_hits [4];

      function new();
         errors = 0;
         checked = 0;
         requests = 0;
         settings = 1;
         foreach (status_hits[s]) status_hits[s] = 0;
         total = NUM_BLOCKS;
         rebuild();
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] MISMATCH %s", $time, what);
      endtask

      function int unsigned order_of(int unsigned n);
         int unsigned k;
         k = 0;
         while (k < 7 && (1 << k) < n) k++;
         return k;
      endfunction

      function logic [63:0] span(int unsigned base, int unsigned n);
         logic [63:0] m;
         m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
         return m << base;
      endfunction

      // Largest piece first, starting at block 0.
      function void rebuild();
         int unsigned pos;
         int unsigned size;
         int          d;
         pos = 0;
         free_count = 0;
         top_order = 0;
         for (d = 0; d <= MAX_ORDER; d++) free_map[d] = '0;
         for (d = MAX_ORDER; d >= 0; d--) begin
            size = 1 << d;
            if ((total & size) != 0 && pos + size <= 64) begin
               if (free_count == 0) top_order = d;
               free_map[d][pos] = 1'b1;
               pos += size;
               free_count += size;
            end
         end
      endfunction

      function void set_total(logic [CNT_W-1:0] v);
         total = (v > NUM_BLOCKS) ? NUM_BLOCKS : v;
         rebuild();
         live.delete();
         settings++;
      endfunction

      function logic [63:0] covered();
         logic [63:0] cov;
         int unsigned o;
         int unsigned i;
         cov = '0;
         for (o = 0; o <= MAX_ORDER; o++)
            for (i = 0; i < 64; i++)
               if (free_map[o][i]) cov |= span(i, (i + (1 << o) <= 64) ? (1 << o) : 64 - i);
         return cov;
      endfunction

      function status_type take(int unsigned cnt, output int unsigned granted);
         int unsigned k;
         int unsigned o;
         int unsigned idx;
         int unsigned p;
         granted = 0;
         if (cnt == 0) return STAT_INVALID;
         k = order_of(cnt);
         if ((1 << k) > free_count) return STAT_TOO_FEW;
         if (k > MAX_ORDER || k > top_order) return STAT_NO_PIECE;
         o = k;
         while (o <= top_order && o <= MAX_ORDER && free_map[o] == '0) o++;
         if (o > top_order || o > MAX_ORDER) return STAT_NO_PIECE;
         idx = 0;
         while (!free_map[o][idx]) idx++;
         free_map[o][idx] = 1'b0;
         // The upper halves of every split go back to the free sets.
         for (p = k; p < o; p++)
            if (idx + (1 << p) < 64) free_map[p][idx + (1 << p)] = 1'b1;
         free_count -= 1 << k;
         granted = idx;
         return STAT_OK;
      endfunction

      function status_type give_back(int unsigned cnt, int unsigned base);
         int unsigned k;
         int unsigned size;
         int unsigned idx;
         int unsigned buddy;
         int          j;
         if (cnt == 0) return STAT_INVALID;
         k = order_of(cnt);
         if (k > MAX_ORDER) return STAT_INVALID;
         size = 1 << k;
         if ((base & (size - 1)) != 0) return STAT_INVALID;
         if (base + size > total || base + size > 64) return STAT_INVALID;
         if ((covered() & span(base, size)) != '0) return STAT_INVALID;
         free_count += size;
         for (j = live.size() - 1; j >= 0; j--)
            if (live[j].base < base + size &&
                base < live[j].base + (1 << order_of(live[j].count))) live.delete(j);
         idx = base;
         while (k < MAX_ORDER) begin
            buddy = idx ^ (1 << k);
            if (buddy >= total || buddy >= 64) break;
            if (!free_map[k][buddy]) break;
            free_map[k][buddy] = 1'b0;
            if (buddy < idx) idx = buddy;
            k++;
         end
         free_map[k][idx] = 1'b1;
         return STAT_OK;
      endfunction

      function void note_request(command_type cmd, logic [CNT_W-1:0] cnt,
                                 logic [IDX_W-1:0] idx);
         outcome_type e;
         int unsigned g;
         piece_type   pc;
         g = 0;
         if (cmd == CMD_ALLOC) begin
            e.status = take(cnt, g);
            if (e.status == STAT_OK) begin
               pc.base = g;
               pc.count = cnt;
               live.push_back(pc);
            end
         end else begin
            e.status = give_back(cnt, idx);
         end
         e.granted = g[IDX_W-1:0];
         e.free_total = free_count[CNT_W-1:0];
         expected_q.push_back(e);
         status_hits[e.status]++;
         requests++;
      endfunction

      task check_result(status_type st, logic [IDX_W-1:0] gi, logic [CNT_W-1:0] ft);
         outcome_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("response beat with nothing outstanding, status %0d", st));
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (st !== e.status)
            report($sformatf("response %0d: status %0d, expected %0d", checked, st, e.status));
         if (gi !== e.granted)
            report($sformatf("response %0d: granted_index %0d, expected %0d",
                             checked, gi, e.granted));
         if (ft !== e.free_total)
            report($sformatf("response %0d: free_total %0d, expected %0d",
                             checked, ft, e.free_total));
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();
   bba_csr_if csr_bus ();

   allocator_board_type board;
   bit                  no_idle = 1'b0;
   int unsigned         rsp_gap = 0;
   int unsigned         hold_left = 0;

   buddy_block_allocator_unit #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .MAX_ORDER (MAX_ORDER)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response side: ready drops for a drawn number of cycles after each beat, and for
   // the whole of a long hold-off when one is requested.
   initial begin : rsp_sink
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_result(rsp_bus.status, rsp_bus.granted_index, rsp_bus.free_total);
         rsp_gap = no_idle ? 0 : $urandom_range(0, 10);
      end
   end

   // Called at a falling edge; returns at a falling edge after the beat and its idle gap.
   task automatic send_request(command_type cmd, int unsigned cnt, int unsigned idx);
      int unsigned gap;
      req_bus.valid = 1'b1;
      req_bus.command = cmd;
      req_bus.block_count = cnt[CNT_W-1:0];
      req_bus.block_index = idx[IDX_W-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(cmd, cnt[CNT_W-1:0], idx[IDX_W-1:0]);
      @(negedge clock);
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_total(int unsigned v);
      csr_bus.valid = 1'b1;
      csr_bus.total_blocks = v[CNT_W-1:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.set_total(v[CNT_W-1:0]);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Mostly allocates and frees of pieces actually held, with some malformed frees mixed in.
   task automatic random_request(output command_type cmd, output int unsigned cnt,
                                 output int unsigned idx);
      int unsigned r;
      int unsigned j;
      int unsigned k;
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, 63);
      if (r < 45) begin
         cmd = CMD_ALLOC;
         r = $urandom_range(0, 99);
         if (r < 3) cnt = 0;
         else if (r < 8) cnt = $urandom_range(65, 127);
         else if (r < 22) cnt = $urandom_range(9, 64);
         else cnt = $urandom_range(1, 8);
      end else if (r < 85 && board.live.size() > 0) begin
         cmd = CMD_FREE;
         j = $urandom_range(0, board.live.size() - 1);
         idx = board.live[j].base;
         k = board.order_of(board.live[j].count);
         cnt = (k == 0) ? 1 : $urandom_range((1 << (k - 1)) + 1, 1 << k);
      end else begin
         cmd = CMD_FREE;
         cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
         if ($urandom_range(0, 1) == 1)
            idx = idx & ~((1 << board.order_of(cnt)) - 1) & 63;
      end
   endtask

   initial begin : stimulus
      command_type cmd;
      int unsigned cnt;
      int unsigned idx;
      int unsigned totals [9];
      int          ph;
      int          n;
      board = new();
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ALLOC;
      req_bus.block_count = '0;
      req_bus.block_index = '0;
      csr_bus.valid = 1'b0;
      csr_bus.total_blocks = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Full region after reset: zero counts, the whole region, splits, bad frees, merges.
      send_request(CMD_ALLOC, 0, 0);
      send_request(CMD_FREE, 0, 0);
      send_request(CMD_ALLOC, 64, 0);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_FREE, 64, 0);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_ALLOC, 3, 0);
      send_request(CMD_FREE, 1, 1);
      send_request(CMD_FREE, 4, 2);
      send_request(CMD_FREE, 127, 63);
      send_request(CMD_FREE, 1, 0);
      send_request(CMD_FREE, 3, 4);
      drain();

      // An odd total: an order above the top one, and a piece running past the end.
      write_total(45);
      send_request(CMD_ALLOC, 33, 0);
      send_request(CMD_ALLOC, 16, 0);
      send_request(CMD_FREE, 2, 44);
      send_request(CMD_FREE, 16, 0);
      drain();

      // Enough free blocks but no piece large enough.
      write_total(4);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_FREE, 1, 1);
      send_request(CMD_ALLOC, 2, 0);
      drain();

      // An empty region.
      write_total(0);
      send_request(CMD_ALLOC, 1, 0);
      send_request(CMD_FREE, 1, 0);
      drain();

      totals = '{127, 64, 1, 37, 63, 2, $urandom_range(1, 127), $urandom_range(1, 64), 64};
      for (ph = 0; ph < 9; ph++) begin
         write_total(totals[ph]);
         no_idle = (ph == 3);
         if (ph == 1) begin
            // Starve the response side while requests keep coming.
            @(posedge clock);
            hold_left = 200;
            @(negedge clock);
         end
         for (n = 0; n < 50; n++) begin
            random_request(cmd, cnt, idx);
            send_request(cmd, cnt, idx);
         end
         drain();
      end
      no_idle = 1'b0;

      repeat (40) @(posedge clock);
      $display("Covered %0d requests over %0d register settings; %0d responses checked.",
               board.requests, board.settings, board.checked);
      $display("Outcomes seen: ok %0d, invalid %0d, too few %0d, no piece %0d.",
               board.status_hits[STAT_OK], board.status_hits[STAT_INVALID],
               board.status_hits[STAT_TOO_FEW], board.status_hits[STAT_NO_PIECE]);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("Timed out waiting on the allocator.");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
